>>> src/mcsm_pkg.sv
// ----------------------------------------------------------------------------
// mcsm_pkg: shared types and constants of the control surface mapper
// Holds the field widths, the command that passes from the front end to the
// back end, the controller and note tables, and the LED colour helpers.
// ----------------------------------------------------------------------------
package mcsm_pkg;

    localparam int KNOB_COUNT_DEF   = 24;
    localparam int LAYOUT_COUNT_DEF = 9;
    localparam int STEP_COUNT_DEF   = 16;
    localparam int FADER_COUNT_DEF  = 8;

    localparam int CH_W       = 4;
    localparam int VAL_W      = 7;
    localparam int IDX_W      = 5;
    localparam int KIND_W     = 2;
    localparam int TGT_W      = 6;
    localparam int LAYOUT_W   = 4;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIDI_CHANNEL  = 1'b0,
        REG_PICKUP_WINDOW = 1'b1
    } cfg_reg_t;

    localparam logic [CH_W-1:0]  CHANNEL_RST = 4'd8;
    localparam logic [VAL_W-1:0] WINDOW_RST  = 7'd2;

    localparam logic [3:0] ST_CC  = 4'hb;
    localparam logic [3:0] ST_ON  = 4'h9;
    localparam logic [3:0] ST_OFF = 4'h8;

    localparam logic [VAL_W-1:0] NOTE_DEVICE  = 7'd105;
    localparam logic [VAL_W-1:0] COL_GREEN    = 7'd60;
    localparam logic [VAL_W-1:0] COL_YELLOW   = 7'd62;
    localparam logic [VAL_W-1:0] COL_RED      = 7'd15;
    localparam logic [VAL_W-1:0] COL_OFF      = 7'd12;
    localparam logic [VAL_W-1:0] COL_AMBER    = 7'd63;
    localparam logic [VAL_W-1:0] TEMPLATE_NUM = 7'd8;
    localparam logic [TGT_W-1:0] LED_BUTTON_BASE = 6'd24;

    typedef enum logic [KIND_W-1:0] {
        KIND_LED      = 2'd0,
        KIND_FADER    = 2'd1,
        KIND_TEMPLATE = 2'd2,
        KIND_RESET    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_FADER,
        OP_KNOB,
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_TAKE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [IDX_W-1:0]    idx;
        logic [VAL_W-1:0]    val;
        logic                present;
        logic                is_device;
        logic                is_focus0;
        logic                key_valid;
        logic [LAYOUT_W-1:0] key_layout;
        logic                btn_valid;
        logic [STEP_W-1:0]   btn;
    } cmd_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ONE,
        S_KNOB_RD,
        S_KNOB_EX,
        S_TMPL,
        S_LEDRST,
        S_SWEEP_RD,
        S_SWEEP_KNOB,
        S_SWEEP_BTN
    } state_t;

    localparam logic [VAL_W-1:0] KNOB_CC [24] = '{
        7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20,
        7'd29, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36,
        7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56};
    localparam logic [VAL_W-1:0] FADER_CC [8] = '{
        7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82, 7'd83, 7'd84};
    localparam logic [VAL_W-1:0] FOCUS_NOTE [8] = '{
        7'd41, 7'd42, 7'd43, 7'd44, 7'd57, 7'd58, 7'd59, 7'd60};
    localparam logic [VAL_W-1:0] CONTROL_NOTE [8] = '{
        7'd73, 7'd74, 7'd75, 7'd76, 7'd89, 7'd90, 7'd91, 7'd92};

    function automatic lookup_t knob_of_cc(input logic [VAL_W-1:0] cc);
        lookup_t r;
        r = '0;
        for (int i = 0; i < 24; i++) begin
            if (cc == KNOB_CC[i]) begin
                r.hit = 1'b1;
                r.idx = IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic lookup_t fader_of_cc(input logic [VAL_W-1:0] cc);
        lookup_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (cc == FADER_CC[i]) begin
                r.hit = 1'b1;
                r.idx = IDX_W'(i);
            end
        end
        return r;
    endfunction

    // Focus notes map to buttons 0-7, control notes to buttons 8-15.
    function automatic lookup_t button_of(input logic [VAL_W-1:0] note);
        lookup_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (note == FOCUS_NOTE[i]) begin
                r.hit = 1'b1;
                r.idx = IDX_W'(i);
            end
            if (note == CONTROL_NOTE[i]) begin
                r.hit = 1'b1;
                r.idx = IDX_W'(8 + i);
            end
        end
        return r;
    endfunction

    function automatic lookup_t control_of(input logic [VAL_W-1:0] note);
        lookup_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (note == CONTROL_NOTE[i]) begin
                r.hit = 1'b1;
                r.idx = IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] knob_colour(
        input logic             known,
        input logic             picked,
        input logic [VAL_W-1:0] pos,
        input logic [VAL_W-1:0] stored,
        input logic [VAL_W-1:0] win
    );
        logic [VAL_W-1:0] gap;
        gap = (pos > stored) ? (pos - stored) : (stored - pos);
        if (!known) begin
            return COL_OFF;
        end
        else if (picked || (gap <= win)) begin
            return COL_GREEN;
        end
        else if (pos < stored) begin
            return COL_YELLOW;
        end
        return COL_RED;
    endfunction

    // The playhead never advances, so step 0 always shows red.
    function automatic logic [VAL_W-1:0] step_colour(
        input logic [STEP_W-1:0] s,
        input logic [15:0]       pattern,
        input logic [STEP_W-1:0] loop_start,
        input logic [STEP_W-1:0] loop_end
    );
        if (s == '0) begin
            return COL_RED;
        end
        else if ((s == loop_start) || (s == loop_end)) begin
            return COL_AMBER;
        end
        else if (pattern[s]) begin
            return COL_GREEN;
        end
        return COL_OFF;
    endfunction

endpackage

>>> src/mcsm_if.sv
// ----------------------------------------------------------------------------
// mcsm_if: channel interfaces of the control surface mapper
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface mcsm_in_if;
    import mcsm_pkg::*;
    logic             valid;
    logic             ready;
    logic             action;
    logic [3:0]       status_nibble;
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] data_one;
    logic [VAL_W-1:0] data_two;
    logic             output_present;
    modport source (output valid, action, status_nibble, channel, data_one, data_two,
                    output_present, input ready);
    modport sink (input valid, action, status_nibble, channel, data_one, data_two,
                  output_present, output ready);
endinterface

interface mcsm_out_if;
    import mcsm_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TGT_W-1:0]  target_index;
    logic [VAL_W-1:0]  payload;
    logic              taken_over;
    logic              last;
    modport source (output valid, kind, target_index, payload, taken_over, last,
                    input ready);
    modport sink (input valid, kind, target_index, payload, taken_over, last,
                  output ready);
endinterface

interface mcsm_cfg_if;
    import mcsm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/mcsm_ram.sv
// ----------------------------------------------------------------------------
// mcsm_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> src/mcsm_front.sv
// ----------------------------------------------------------------------------
// mcsm_front: request decoder
// Holds the configuration registers, filters requests by channel and status
// and turns them into commands for the back end.
// ----------------------------------------------------------------------------
module mcsm_front #(
    parameter int KNOB_COUNT   = mcsm_pkg::KNOB_COUNT_DEF,
    parameter int LAYOUT_COUNT = mcsm_pkg::LAYOUT_COUNT_DEF,
    parameter int FADER_COUNT  = mcsm_pkg::FADER_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    mcsm_in_if.sink                   in_ch,
    mcsm_cfg_if.sink                  cfg_ch,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output mcsm_pkg::cmd_t            cmd,
    output logic [mcsm_pkg::VAL_W-1:0] window
);
    import mcsm_pkg::*;

    logic [CH_W-1:0]  chan_reg, chan_next;
    logic [VAL_W-1:0] win_reg, win_next;
    logic             cmd_valid_reg, cmd_valid_next;
    cmd_t             cmd_reg, cmd_next;
    cmd_t             dec;
    logic             keep;
    logic             accept;
    lookup_t          knob_hit, fader_hit, btn_hit, ctrl_hit;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !cmd_valid_reg || cmd_ready;
    assign accept       = in_ch.valid && in_ch.ready;

    always_comb
    begin
        chan_next = chan_reg;
        win_next  = win_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_reg_t'(cfg_ch.index))
                REG_MIDI_CHANNEL:  chan_next = cfg_ch.data[CH_W-1:0];
                REG_PICKUP_WINDOW: win_next  = cfg_ch.data;
                default:           chan_next = chan_reg;
            endcase
        end
    end

    always_comb
    begin
        knob_hit  = knob_of_cc(in_ch.data_one);
        fader_hit = fader_of_cc(in_ch.data_one);
        btn_hit   = button_of(in_ch.data_one);
        ctrl_hit  = control_of(in_ch.data_one);
        dec            = '0;
        dec.op         = OP_TAKE;
        dec.val        = in_ch.data_two;
        dec.present    = in_ch.output_present;
        dec.is_device  = (in_ch.data_one == NOTE_DEVICE);
        dec.is_focus0  = (in_ch.data_one == FOCUS_NOTE[0]);
        dec.key_valid  = ctrl_hit.hit && ((32'(ctrl_hit.idx) + 1) < LAYOUT_COUNT);
        dec.key_layout = LAYOUT_W'(ctrl_hit.idx + 1'b1);
        dec.btn_valid  = btn_hit.hit;
        dec.btn        = btn_hit.idx[STEP_W-1:0];
        keep = 1'b0;
        if (in_ch.action)
        begin
            keep = 1'b1;
        end
        else if (in_ch.channel == chan_reg)
        begin
            case (in_ch.status_nibble)
                ST_CC:
                begin
                    if (fader_hit.hit)
                    begin
                        dec.op  = OP_FADER;
                        dec.idx = fader_hit.idx;
                        keep    = (32'(fader_hit.idx) < FADER_COUNT);
                    end
                    else if (knob_hit.hit)
                    begin
                        dec.op  = OP_KNOB;
                        dec.idx = knob_hit.idx;
                        keep    = (32'(knob_hit.idx) < KNOB_COUNT);
                    end
                end
                ST_ON:
                begin
                    // A note on with zero velocity is a note off.
                    dec.op = (in_ch.data_two == '0) ? OP_NOTE_OFF : OP_NOTE_ON;
                    keep   = dec.is_device || btn_hit.hit;
                end
                ST_OFF:
                begin
                    dec.op = OP_NOTE_OFF;
                    keep   = dec.is_device || btn_hit.hit;
                end
                default:
                begin
                    keep = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        cmd_next       = cmd_reg;
        if (accept && keep)
        begin
            cmd_valid_next = 1'b1;
            cmd_next       = dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg      <= CHANNEL_RST;
            win_reg       <= WINDOW_RST;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            chan_reg      <= chan_next;
            win_reg       <= win_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;
    assign window    = win_reg;
endmodule

>>> src/mcsm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mcsm_cmd_fifo: command queue
// A short queue that lets the decoder and the executor stall separately.
// ----------------------------------------------------------------------------
module mcsm_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mcsm_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mcsm_pkg::cmd_t pop_cmd
);
    import mcsm_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    cmd_t          mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end
endmodule

>>> src/mcsm_back.sv
// ----------------------------------------------------------------------------
// mcsm_back: command executor
// Owns the surface state, runs one command at a time and sends its results
// through an output register, sweeping all LEDs, or the button LEDs alone, where a command needs it.
// ----------------------------------------------------------------------------
module mcsm_back #(
    parameter int KNOB_COUNT   = mcsm_pkg::KNOB_COUNT_DEF,
    parameter int LAYOUT_COUNT = mcsm_pkg::LAYOUT_COUNT_DEF,
    parameter int STEP_COUNT   = mcsm_pkg::STEP_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  mcsm_pkg::cmd_t             cmd,
    input  logic [mcsm_pkg::VAL_W-1:0] window,
    mcsm_out_if.source                 out_ch
);
    import mcsm_pkg::*;

    localparam int LW   = $clog2(LAYOUT_COUNT);
    localparam int KW   = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;
    localparam int KD   = LAYOUT_COUNT * KNOB_COUNT;
    localparam int KA_W = $clog2(KD);

    state_t state_reg, state_next;

    logic [LW-1:0]     layout_reg, layout_next;
    logic              device_reg, device_next;
    logic              held_reg, held_next;
    logic [STEP_W-1:0] held_step_reg, held_step_next;
    logic              loop_set_reg, loop_set_next;
    logic              taken_reg, taken_next;
    logic [15:0]       gate_reg, gate_next;
    logic [15:0]       pattern_reg [LAYOUT_COUNT];
    logic [15:0]       pattern_next [LAYOUT_COUNT];
    logic [STEP_W-1:0] lstart_reg [LAYOUT_COUNT];
    logic [STEP_W-1:0] lstart_next [LAYOUT_COUNT];
    logic [STEP_W-1:0] lend_reg [LAYOUT_COUNT];
    logic [STEP_W-1:0] lend_next [LAYOUT_COUNT];
    logic [VAL_W-1:0]  pos_reg [KNOB_COUNT];
    logic [VAL_W-1:0]  pos_next [KNOB_COUNT];
    logic [KNOB_COUNT-1:0] known_reg, known_next;
    logic [KNOB_COUNT-1:0] picked_reg, picked_next;
    logic [KD-1:0]     kvalid_reg, kvalid_next;
    logic              kvalid_rd_reg;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    kind_t             pend_kind_reg, pend_kind_next;
    logic [TGT_W-1:0]  pend_tgt_reg, pend_tgt_next;
    logic [VAL_W-1:0]  pend_pay_reg, pend_pay_next;

    logic              ov_reg, ov_next;
    kind_t             ok_reg, ok_next;
    logic [TGT_W-1:0]  ot_reg, ot_next;
    logic [VAL_W-1:0]  op_reg, op_next;
    logic              otk_reg, otk_next;
    logic              ol_reg, ol_next;

    logic              pop, slot_free, push;
    kind_t             r_kind;
    logic [TGT_W-1:0]  r_tgt;
    logic [VAL_W-1:0]  r_pay;
    logic              r_last;
    logic              l_zero, step_ok, held_match, sw_valid, sw_change, on_plain;
    logic              off_toggle, knob_last, btn_last;
    logic [LW-1:0]     sw_layout;
    logic [KW-1:0]     k;
    logic [KA_W-1:0]   kaddr;
    logic              ram_we;
    logic [VAL_W-1:0]  ram_rdata, stored;
    logic [VAL_W-1:0]  kdist;
    logic              kpick;
    logic [15:0]       tog_pattern, tog_gate;

    assign pop        = (state_reg == S_IDLE) && cmd_valid;
    assign cmd_ready  = (state_reg == S_IDLE);
    assign slot_free  = !ov_reg || out_ch.ready;
    assign l_zero     = (layout_reg == '0);
    assign step_ok    = cmd.btn_valid && (32'(cmd.btn) < STEP_COUNT);
    assign held_match = held_reg && (cmd.btn == held_step_reg);
    assign sw_valid   = device_reg && !cmd.is_device && (cmd.is_focus0 || cmd.key_valid);
    assign sw_layout  = cmd.is_focus0 ? '0 : LW'(cmd.key_layout);
    assign sw_change  = sw_valid && (sw_layout != layout_reg);
    assign on_plain   = !cmd.is_device && !sw_valid && cmd.btn_valid;
    assign off_toggle = !cmd.is_device && !l_zero && step_ok && held_match && !loop_set_reg;
    assign knob_last  = (cnt_reg == IDX_W'(KNOB_COUNT - 1));
    assign btn_last   = l_zero ? (cnt_reg == IDX_W'(15)) : (cnt_reg == IDX_W'(STEP_COUNT - 1));
    assign k          = cnt_reg[KW-1:0];
    assign kaddr      = KA_W'(layout_reg) * KA_W'(KNOB_COUNT) + KA_W'(cnt_reg);
    assign stored     = kvalid_rd_reg ? ram_rdata : '0;
    assign kdist      = (val_reg > stored) ? (val_reg - stored) : (stored - val_reg);
    assign kpick      = picked_reg[k] || (kdist <= window);
    assign tog_pattern = pattern_reg[layout_reg] ^ (16'd1 << cmd.btn);
    assign tog_gate    = gate_reg ^ (16'd1 << cmd.btn);

    mcsm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (KD)
    ) u_knob_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (kaddr),
        .wdata (val_reg),
        .raddr (kaddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    case (cmd.op)
                        OP_FADER: state_next = S_ONE;
                        OP_KNOB:  state_next = S_KNOB_RD;
                        OP_NOTE_ON:
                        begin
                            if (sw_change)
                            begin
                                state_next = S_SWEEP_RD;
                            end
                            else if (on_plain && l_zero)
                            begin
                                state_next = S_ONE;
                            end
                            else if (on_plain && step_ok && held_reg)
                            begin
                                state_next = S_SWEEP_BTN;
                            end
                        end
                        OP_NOTE_OFF:
                        begin
                            if (off_toggle)
                            begin
                                state_next = S_ONE;
                            end
                        end
                        OP_TAKE:
                        begin
                            if (!taken_reg && cmd.present)
                            begin
                                state_next = S_TMPL;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ONE:        state_next = slot_free ? S_IDLE : S_ONE;
            S_KNOB_RD:    state_next = S_KNOB_EX;
            S_KNOB_EX:    state_next = slot_free ? S_IDLE : S_KNOB_EX;
            S_TMPL:       state_next = slot_free ? S_LEDRST : S_TMPL;
            S_LEDRST:     state_next = slot_free ? S_SWEEP_RD : S_LEDRST;
            S_SWEEP_RD:   state_next = S_SWEEP_KNOB;
            S_SWEEP_KNOB:
            begin
                if (slot_free)
                begin
                    state_next = knob_last ? S_SWEEP_BTN : S_SWEEP_RD;
                end
            end
            S_SWEEP_BTN:  state_next = (slot_free && btn_last) ? S_IDLE : S_SWEEP_BTN;
            default:      state_next = S_IDLE;
        endcase
    end

    // Results and state updates.
    always_comb
    begin
        layout_next    = layout_reg;
        device_next    = device_reg;
        held_next      = held_reg;
        held_step_next = held_step_reg;
        loop_set_next  = loop_set_reg;
        taken_next     = taken_reg;
        gate_next      = gate_reg;
        pattern_next   = pattern_reg;
        lstart_next    = lstart_reg;
        lend_next      = lend_reg;
        pos_next       = pos_reg;
        known_next     = known_reg;
        picked_next    = picked_reg;
        kvalid_next    = kvalid_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        pend_kind_next = pend_kind_reg;
        pend_tgt_next  = pend_tgt_reg;
        pend_pay_next  = pend_pay_reg;
        ram_we         = 1'b0;
        push           = 1'b0;
        r_kind         = KIND_LED;
        r_tgt          = '0;
        r_pay          = '0;
        r_last         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    case (cmd.op)
                        OP_FADER:
                        begin
                            pend_kind_next = KIND_FADER;
                            pend_tgt_next  = TGT_W'(cmd.idx);
                            pend_pay_next  = cmd.val;
                        end
                        OP_KNOB:
                        begin
                            cnt_next = cmd.idx;
                            val_next = cmd.val;
                        end
                        OP_NOTE_ON:
                        begin
                            if (cmd.is_device)
                            begin
                                device_next = 1'b1;
                            end
                            else if (sw_valid)
                            begin
                                if (sw_change)
                                begin
                                    layout_next = sw_layout;
                                    picked_next = '0;
                                    cnt_next    = '0;
                                end
                            end
                            else if (cmd.btn_valid)
                            begin
                                if (l_zero)
                                begin
                                    gate_next      = tog_gate;
                                    pend_kind_next = KIND_LED;
                                    pend_tgt_next  = LED_BUTTON_BASE + TGT_W'(cmd.btn);
                                    pend_pay_next  = tog_gate[cmd.btn] ? COL_GREEN : COL_OFF;
                                end
                                else if (step_ok)
                                begin
                                    if (!held_reg)
                                    begin
                                        held_next      = 1'b1;
                                        held_step_next = cmd.btn;
                                        loop_set_next  = 1'b0;
                                    end
                                    else
                                    begin
                                        lstart_next[layout_reg] = (held_step_reg < cmd.btn) ?
                                                                  held_step_reg : cmd.btn;
                                        lend_next[layout_reg]   = (held_step_reg > cmd.btn) ?
                                                                  held_step_reg : cmd.btn;
                                        loop_set_next = 1'b1;
                                        cnt_next      = '0;
                                    end
                                end
                            end
                        end
                        OP_NOTE_OFF:
                        begin
                            if (cmd.is_device)
                            begin
                                device_next = 1'b0;
                            end
                            else if (!l_zero && step_ok && held_match)
                            begin
                                if (!loop_set_reg)
                                begin
                                    pattern_next[layout_reg] = tog_pattern;
                                    pend_kind_next = KIND_LED;
                                    pend_tgt_next  = LED_BUTTON_BASE + TGT_W'(cmd.btn);
                                    pend_pay_next  = step_colour(cmd.btn, tog_pattern,
                                                                 lstart_reg[layout_reg],
                                                                 lend_reg[layout_reg]);
                                end
                                held_next     = 1'b0;
                                loop_set_next = 1'b0;
                            end
                        end
                        OP_TAKE:
                        begin
                            if (!taken_reg && !cmd.present)
                            begin
                                taken_next = 1'b1;
                            end
                            cnt_next = '0;
                        end
                        default: cnt_next = cnt_reg;
                    endcase
                end
            end
            S_ONE:
            begin
                push   = slot_free;
                r_kind = pend_kind_reg;
                r_tgt  = pend_tgt_reg;
                r_pay  = pend_pay_reg;
                r_last = 1'b1;
            end
            S_KNOB_EX:
            begin
                push   = slot_free;
                r_tgt  = TGT_W'(cnt_reg);
                r_pay  = knob_colour(1'b1, kpick, val_reg, kpick ? val_reg : stored, window);
                r_last = 1'b1;
                if (slot_free)
                begin
                    picked_next[k] = kpick;
                    pos_next[k]    = val_reg;
                    known_next[k]  = 1'b1;
                    if (kpick)
                    begin
                        ram_we             = 1'b1;
                        kvalid_next[kaddr] = 1'b1;
                    end
                end
            end
            S_TMPL:
            begin
                push   = slot_free;
                r_kind = KIND_TEMPLATE;
                r_pay  = TEMPLATE_NUM;
            end
            S_LEDRST:
            begin
                push   = slot_free;
                r_kind = KIND_RESET;
                if (slot_free)
                begin
                    taken_next = 1'b1;
                end
            end
            S_SWEEP_KNOB:
            begin
                push  = slot_free;
                r_tgt = TGT_W'(cnt_reg);
                r_pay = knob_colour(known_reg[k], picked_reg[k], pos_reg[k], stored, window);
                if (slot_free)
                begin
                    cnt_next = knob_last ? '0 : cnt_reg + 1'b1;
                end
            end
            S_SWEEP_BTN:
            begin
                push   = slot_free;
                r_tgt  = LED_BUTTON_BASE + TGT_W'(cnt_reg);
                r_last = btn_last;
                if (l_zero)
                begin
                    r_pay = gate_reg[cnt_reg[STEP_W-1:0]] ? COL_GREEN : COL_OFF;
                end
                else
                begin
                    r_pay = step_colour(cnt_reg[STEP_W-1:0], pattern_reg[layout_reg],
                                        lstart_reg[layout_reg], lend_reg[layout_reg]);
                end
                if (slot_free)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: push = 1'b0;
        endcase
    end

    always_comb
    begin
        ov_next  = ov_reg && !out_ch.ready;
        ok_next  = ok_reg;
        ot_next  = ot_reg;
        op_next  = op_reg;
        otk_next = otk_reg;
        ol_next  = ol_reg;
        if (push)
        begin
            ov_next  = 1'b1;
            ok_next  = r_kind;
            ot_next  = r_tgt;
            op_next  = r_pay;
            otk_next = taken_reg;
            ol_next  = r_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            layout_reg    <= '0;
            device_reg    <= 1'b0;
            held_reg      <= 1'b0;
            held_step_reg <= '0;
            loop_set_reg  <= 1'b0;
            taken_reg     <= 1'b0;
            gate_reg      <= '0;
            for (int i = 0; i < LAYOUT_COUNT; i++)
            begin
                pattern_reg[i] <= '0;
                lstart_reg[i]  <= '0;
                lend_reg[i]    <= STEP_W'(STEP_COUNT - 1);
            end
            known_reg     <= '0;
            picked_reg    <= '1;
            kvalid_reg    <= '0;
            cnt_reg       <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            layout_reg    <= layout_next;
            device_reg    <= device_next;
            held_reg      <= held_next;
            held_step_reg <= held_step_next;
            loop_set_reg  <= loop_set_next;
            taken_reg     <= taken_next;
            gate_reg      <= gate_next;
            pattern_reg   <= pattern_next;
            lstart_reg    <= lstart_next;
            lend_reg      <= lend_next;
            known_reg     <= known_next;
            picked_reg    <= picked_next;
            kvalid_reg    <= kvalid_next;
            cnt_reg       <= cnt_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        kvalid_rd_reg <= kvalid_reg[kaddr];
        pend_kind_reg <= pend_kind_next;
        pend_tgt_reg  <= pend_tgt_next;
        pend_pay_reg  <= pend_pay_next;
        ok_reg        <= ok_next;
        ot_reg        <= ot_next;
        op_reg        <= op_next;
        otk_reg       <= otk_next;
        ol_reg        <= ol_next;
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.kind         = ok_reg;
    assign out_ch.target_index = ot_reg;
    assign out_ch.payload      = op_reg;
    assign out_ch.taken_over   = otk_reg;
    assign out_ch.last         = ol_reg;

    a_taken_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg |=> taken_reg)
        else $error("takeover flag cleared");

    a_layout_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(layout_reg) < LAYOUT_COUNT)
        else $error("layout out of range");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> (32'(held_step_reg) < STEP_COUNT))
        else $error("held step out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(ov_reg && !out_ch.ready))
        else $error("result overwritten while stalled");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (state_next != S_IDLE)) |=> (state_reg != S_IDLE) && !cmd_ready)
        else $error("command taken while busy");
endmodule

>>> src/midi_control_surface_mapper.sv
// ----------------------------------------------------------------------------
// midi_control_surface_mapper: MIDI control surface state keeper
// Decodes MIDI requests on one channel, keeps fader, knob, gate and step
// state and answers with LED, fader, template and reset results.
//
//   channel   dir   handshake      carries
//   in_ch     in    valid/ready    action, status, channel, data, link flag
//   out_ch    out   valid/ready    kind, target, payload, taken flag, last
//   cfg_ch    in    valid/ready    register index and write data
//
// A layout switch or a takeover sweeps all LEDs: each knob in a read state
// and a result state (the knob store read is registered), then each button.
// The executor handles one command at a time; up to three decoded requests
// wait in the decode register and the command queue meanwhile.
// Reset is asynchronous and active low; it clears all state, no clearing pass.
// A stall on out_ch holds the executor; the decoder goes on until the queue and decode register are full.
// ----------------------------------------------------------------------------
module midi_control_surface_mapper #(
    parameter int KNOB_COUNT   = mcsm_pkg::KNOB_COUNT_DEF,
    parameter int LAYOUT_COUNT = mcsm_pkg::LAYOUT_COUNT_DEF,
    parameter int STEP_COUNT   = mcsm_pkg::STEP_COUNT_DEF,
    parameter int FADER_COUNT  = mcsm_pkg::FADER_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mcsm_in_if.sink    in_ch,
    mcsm_out_if.source out_ch,
    mcsm_cfg_if.sink   cfg_ch
);
    import mcsm_pkg::*;

    // Decoded commands flow from the front end through the queue.
    logic             f_valid, f_ready;
    cmd_t             f_cmd;
    logic             q_valid, q_ready;
    cmd_t             q_cmd;
    logic [VAL_W-1:0] window;

    mcsm_front #(
        .KNOB_COUNT   (KNOB_COUNT),
        .LAYOUT_COUNT (LAYOUT_COUNT),
        .FADER_COUNT  (FADER_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_ch    (cfg_ch),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd),
        .window    (window)
    );

    mcsm_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    // The back end owns all surface state and the output register.
    mcsm_back #(
        .KNOB_COUNT   (KNOB_COUNT),
        .LAYOUT_COUNT (LAYOUT_COUNT),
        .STEP_COUNT   (STEP_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .window    (window),
        .out_ch    (out_ch)
    );
endmodule

>>> dv/midi_control_surface_mapper_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_control_surface_mapper_checker: result predictor and comparator
// Watches the request, result and register write channels. It keeps its own
// copy of the surface state, works out the results that each accepted
// request causes, and compares every accepted result with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module midi_control_surface_mapper_checker
    import mcsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mcsm_in_if.sink    req_mon,
    mcsm_out_if.sink   res_mon,
    mcsm_cfg_if.sink   cfg_mon,
    output int         fail_count,
    output int         pending_count
);

    typedef struct packed {
        kind_t            kind;
        logic [TGT_W-1:0] target;
        logic [VAL_W-1:0] payload;
        logic             taken;
        logic             last;
    } led_result_t;

    localparam int NK = KNOB_COUNT_DEF;
    localparam int NL = LAYOUT_COUNT_DEF;
    localparam int NS = STEP_COUNT_DEF;

    led_result_t      awaited_results[$];
    led_result_t      new_results[$];

    logic [CH_W-1:0]  sel_channel;
    logic [VAL_W-1:0] window;
    logic [VAL_W-1:0] stored_val[NL][NK];
    logic [VAL_W-1:0] pos_val[NK];
    logic             pos_known[NK];
    logic             picked[NK];
    logic [15:0]      gates;
    logic [15:0]      pattern[NL-1];
    logic [3:0]       lp_start[NL-1];
    logic [3:0]       lp_end[NL-1];
    int               cur_layout;
    logic             device_down;
    logic             step_down;
    int               held_btn;
    logic             loop_done;
    logic             is_taken;

    assign pending_count = awaited_results.size();

    function automatic int find_in(input logic [VAL_W-1:0] v,
                                   input logic [VAL_W-1:0] tbl[]);
        for (int i = 0; i < tbl.size(); i++)
            if (tbl[i] == v) return i;
        return -1;
    endfunction

    function automatic void push_result(input kind_t k, input int tgt, input int pl);
        led_result_t r;
        r.kind    = k;
        r.target  = TGT_W'(tgt);
        r.payload = VAL_W'(pl);
        r.taken   = is_taken;
        r.last    = 1'b0;
        new_results.push_back(r);
    endfunction

    function automatic void show_knob(input int k);
        int s;
        int p;
        int d;
        int col;
        s = stored_val[cur_layout][k];
        p = pos_val[k];
        d = (p > s) ? p - s : s - p;
        if (!pos_known[k]) col = COL_OFF;
        else if (picked[k] || d <= window) col = COL_GREEN;
        else if (p < s) col = COL_YELLOW;
        else col = COL_RED;
        push_result(KIND_LED, k, col);
    endfunction

    function automatic void show_step(input int s);
        int q;
        int col;
        q = cur_layout - 1;
        if (s == 0) col = COL_RED;
        else if (s == lp_start[q] || s == lp_end[q]) col = COL_AMBER;
        else if (pattern[q][s]) col = COL_GREEN;
        else col = COL_OFF;
        push_result(KIND_LED, LED_BUTTON_BASE + s, col);
    endfunction

    function automatic void show_all();
        for (int i = 0; i < NK; i++) show_knob(i);
        for (int i = 0; i < 16; i++)
            if (cur_layout == 0)
                push_result(KIND_LED, LED_BUTTON_BASE + i, gates[i] ? COL_GREEN : COL_OFF);
            else if (i < NS)
                show_step(i);
    endfunction

    function automatic int button_index(input logic [VAL_W-1:0] note);
        int f;
        int c;
        f = find_in(note, FOCUS_NOTE);
        c = find_in(note, CONTROL_NOTE);
        if (f >= 0) return f;
        if (c >= 0) return 8 + c;
        return -1;
    endfunction

    function automatic void release_note(input logic [VAL_W-1:0] note);
        int b;
        if (note == NOTE_DEVICE) begin
            device_down = 1'b0;
            return;
        end
        if (cur_layout == 0) return;
        b = button_index(note);
        if (b < 0 || b >= NS) return;
        if (step_down && b == held_btn) begin
            if (!loop_done) begin
                pattern[cur_layout-1][b] = ~pattern[cur_layout-1][b];
                show_step(b);
            end
            step_down = 1'b0;
            loop_done = 1'b0;
        end
    endfunction

    function automatic void press_note(input logic [VAL_W-1:0] note,
                                       input logic [VAL_W-1:0] vel);
        int b;
        int c;
        int nl;
        if (vel == 0) begin
            release_note(note);
            return;
        end
        if (note == NOTE_DEVICE) begin
            device_down = 1'b1;
            return;
        end
        if (device_down) begin
            nl = -1;
            c = find_in(note, CONTROL_NOTE);
            if (note == FOCUS_NOTE[0]) nl = 0;
            else if (c >= 0 && c + 1 < NL) nl = c + 1;
            if (nl >= 0) begin
                // A switch to the layout already shown changes nothing.
                if (nl != cur_layout) begin
                    cur_layout = nl;
                    for (int i = 0; i < NK; i++) picked[i] = 1'b0;
                    show_all();
                end
                return;
            end
        end
        b = button_index(note);
        if (b < 0) return;
        if (cur_layout == 0) begin
            gates[b] = ~gates[b];
            push_result(KIND_LED, LED_BUTTON_BASE + b, gates[b] ? COL_GREEN : COL_OFF);
            return;
        end
        if (b >= NS) return;
        if (!step_down) begin
            step_down = 1'b1;
            held_btn  = b;
            loop_done = 1'b0;
        end
        else begin
            lp_start[cur_layout-1] = 4'((held_btn < b) ? held_btn : b);
            lp_end[cur_layout-1]   = 4'((held_btn > b) ? held_btn : b);
            loop_done = 1'b1;
            for (int i = 0; i < NS; i++) show_step(i);
        end
    endfunction

    function automatic void turn_control(input logic [VAL_W-1:0] cc,
                                         input logic [VAL_W-1:0] v);
        int f;
        int k;
        int s;
        int d;
        f = find_in(cc, FADER_CC);
        k = find_in(cc, KNOB_CC);
        if (f >= 0) begin
            push_result(KIND_FADER, f, v);
        end
        else if (k >= 0) begin
            s = stored_val[cur_layout][k];
            d = (v > s) ? v - s : s - v;
            if (!picked[k] && d <= window) picked[k] = 1'b1;
            if (picked[k]) stored_val[cur_layout][k] = v;
            pos_val[k]   = v;
            pos_known[k] = 1'b1;
            show_knob(k);
        end
    endfunction

    function automatic void predict_request();
        new_results.delete();
        if (req_mon.action) begin
            if (!is_taken) begin
                // The template and reset results still show the old flag.
                if (req_mon.output_present) begin
                    push_result(KIND_TEMPLATE, 0, TEMPLATE_NUM);
                    push_result(KIND_RESET, 0, 0);
                    is_taken = 1'b1;
                    show_all();
                end
                else begin
                    is_taken = 1'b1;
                end
            end
        end
        else if (req_mon.channel == sel_channel) begin
            if (req_mon.status_nibble == ST_CC)
                turn_control(req_mon.data_one, req_mon.data_two);
            else if (req_mon.status_nibble == ST_ON)
                press_note(req_mon.data_one, req_mon.data_two);
            else if (req_mon.status_nibble == ST_OFF)
                release_note(req_mon.data_one);
        end
        if (new_results.size() > 0) new_results[$].last = 1'b1;
        foreach (new_results[i]) awaited_results.push_back(new_results[i]);
    endfunction

    function automatic void compare_result();
        led_result_t w;
        if (awaited_results.size() == 0) begin
            $error("result with nothing expected: kind %0d target %0d payload %0d",
                   res_mon.kind, res_mon.target_index, res_mon.payload);
            fail_count++;
            return;
        end
        w = awaited_results.pop_front();
        if (res_mon.kind !== w.kind) begin
            $error("kind: expected %0d, actual %0d", w.kind, res_mon.kind);
            fail_count++;
        end
        if (res_mon.target_index !== w.target) begin
            $error("target_index: expected %0d, actual %0d", w.target, res_mon.target_index);
            fail_count++;
        end
        if (res_mon.payload !== w.payload) begin
            $error("payload: expected %0d, actual %0d", w.payload, res_mon.payload);
            fail_count++;
        end
        if (res_mon.taken_over !== w.taken) begin
            $error("taken_over: expected %0d, actual %0d", w.taken, res_mon.taken_over);
            fail_count++;
        end
        if (res_mon.last !== w.last) begin
            $error("last: expected %0d, actual %0d", w.last, res_mon.last);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fail_count  = 0;
            sel_channel = CHANNEL_RST;
            window      = WINDOW_RST;
            for (int l = 0; l < NL; l++)
                for (int k = 0; k < NK; k++) stored_val[l][k] = '0;
            for (int k = 0; k < NK; k++) begin
                pos_val[k]   = '0;
                pos_known[k] = 1'b0;
                picked[k]    = 1'b1;
            end
            gates = '0;
            for (int q = 0; q < NL - 1; q++) begin
                pattern[q]  = '0;
                lp_start[q] = '0;
                lp_end[q]   = 4'(NS - 1);
            end
            cur_layout  = 0;
            device_down = 1'b0;
            step_down   = 1'b0;
            held_btn    = 0;
            loop_done   = 1'b0;
            is_taken    = 1'b0;
            awaited_results.delete();
        end
        else begin
            if (res_mon.valid && res_mon.ready) compare_result();
            if (cfg_mon.valid && cfg_mon.ready) begin
                if (cfg_reg_t'(cfg_mon.index) == REG_MIDI_CHANNEL)
                    sel_channel = cfg_mon.data[CH_W-1:0];
                else
                    window = cfg_mon.data;
            end
            if (req_mon.valid && req_mon.ready) predict_request();
        end
    end

endmodule

>>> dv/midi_control_surface_mapper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_control_surface_mapper_test: top level of the mapper testbench
// Drives MIDI and takeover requests and register writes into the mapper,
// stalls the result side at random, and leaves prediction and comparison to
// the checker. Prints the verdict when everything has drained.
// ----------------------------------------------------------------------------
module midi_control_surface_mapper_test;
    import mcsm_pkg::*;

    // The slowest request sweeps 42 results, and the result side may stall on each one.
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 100;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    int   burst_left;
    int   stall_mode;

    mcsm_in_if  req_ch();
    mcsm_out_if res_ch();
    mcsm_cfg_if cfg_ch();

    midi_control_surface_mapper DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch.sink),
        .out_ch (res_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    midi_control_surface_mapper_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_mon       (req_ch.sink),
        .res_mon       (res_ch.sink),
        .cfg_mon       (cfg_ch.sink),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The timeout fires on a cycle count alone, whatever the stimulus is doing.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("midi_control_surface_mapper_test NOT OK");
                $finish;
            end
        end
    end

    // The result side stalls in modes: never, now and then, or most of the
    // time. The mode changes every so often so that stalls land on every
    // part of a sweep.
    initial begin
        res_ch.ready <= 1'b0;
        stall_mode = 0;
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                default: res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Sends one request and waits for it to be accepted. Bursts of random
    // length alternate with random gaps; a burst keeps valid high.
    task automatic send_request(input logic act, input logic [3:0] st,
                                input logic [3:0] ch, input logic [6:0] d1,
                                input logic [6:0] d2, input logic present);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        req_ch.valid          <= 1'b1;
        req_ch.action         <= act;
        req_ch.status_nibble  <= st;
        req_ch.channel        <= ch;
        req_ch.data_one       <= d1;
        req_ch.data_two       <= d2;
        req_ch.output_present <= present;
        do @(posedge clk); while (!req_ch.ready);
        burst_left--;
        if (burst_left == 0) req_ch.valid <= 1'b0;
    endtask

    task automatic midi(input logic [3:0] st, input logic [6:0] d1, input logic [6:0] d2);
        send_request(1'b0, st, checker_inst.sel_channel, d1, d2, 1'b0);
    endtask

    // Waits until every expected result is in, then lets the mapper settle:
    // requests that cause no result may still be in its queue.
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [6:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [6:0] pick_knob_cc();
        return KNOB_CC[$urandom_range(0, 23)];
    endfunction

    function automatic logic [6:0] pick_button();
        return $urandom_range(0, 1) ? FOCUS_NOTE[$urandom_range(0, 7)]
                                    : CONTROL_NOTE[$urandom_range(0, 7)];
    endfunction

    function automatic logic [6:0] rnd7(input int lo, input int hi);
        return 7'($urandom_range(lo, hi));
    endfunction

    function automatic logic [3:0] rnd4();
        return 4'($urandom_range(0, 15));
    endfunction

    // A random request with a bias toward meaningful traffic: mapped
    // controllers, buttons, device-held layout switches, step pairs, and
    // some noise on other channels, statuses and numbers.
    task automatic random_request();
        logic [6:0] b1;
        logic [6:0] b2;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: midi(ST_CC, pick_knob_cc(), rnd7(0, 127));
            4: midi(ST_CC, FADER_CC[$urandom_range(0, 7)], rnd7(0, 127));
            5, 6: midi(ST_ON, pick_button(), rnd7(1, 127));
            7: begin
                // Layout switch: hold the device button, pick a layout key,
                // release the device button.
                midi(ST_ON, NOTE_DEVICE, rnd7(1, 127));
                midi(ST_ON, $urandom_range(0, 8) == 0 ? FOCUS_NOTE[0]
                            : CONTROL_NOTE[$urandom_range(0, 7)], rnd7(1, 127));
                if ($urandom_range(0, 1)) midi(ST_OFF, NOTE_DEVICE, rnd7(0, 127));
                else midi(ST_ON, NOTE_DEVICE, 7'd0);
            end
            8, 9: begin
                // Step toggle: press and release one button.
                b1 = pick_button();
                midi(ST_ON, b1, rnd7(1, 127));
                midi(ST_OFF, b1, rnd7(0, 127));
            end
            10: begin
                // Loop range: hold one step, press another, release both.
                b1 = pick_button();
                b2 = pick_button();
                midi(ST_ON, b1, rnd7(1, 127));
                midi(ST_ON, b2, rnd7(1, 127));
                midi(ST_OFF, b2, 7'd0);
                midi(ST_ON, b1, 7'd0);
            end
            11: midi(ST_OFF, pick_button(), rnd7(0, 127));
            12: send_request(1'b1, rnd4(), rnd4(), rnd7(0, 127), rnd7(0, 127),
                             1'($urandom_range(0, 1)));
            13: midi($urandom_range(0, 1) ? ST_ON : ST_OFF, NOTE_DEVICE, rnd7(0, 127));
            14: send_request(1'b0, rnd4(), rnd4(), rnd7(0, 127), rnd7(0, 127),
                             1'($urandom_range(0, 1)));
            default: midi(rnd4(), rnd7(0, 127), rnd7(0, 127));
        endcase
    endtask

    initial begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.action         = 1'b0;
        req_ch.status_nibble  = '0;
        req_ch.channel        = '0;
        req_ch.data_one       = '0;
        req_ch.data_two       = '0;
        req_ch.output_present = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_MIDI_CHANNEL;
        cfg_ch.data           = '0;
        burst_left            = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset channel. Knobs first show green, then
        // faders at both ends, gate toggles in the default layout.
        midi(ST_CC, KNOB_CC[0], 7'd0);
        midi(ST_CC, KNOB_CC[23], 7'd127);
        midi(ST_CC, FADER_CC[0], 7'd127);
        midi(ST_CC, FADER_CC[7], 7'd0);
        midi(ST_CC, 7'd0, 7'd5);
        midi(ST_ON, FOCUS_NOTE[0], 7'd127);
        midi(ST_ON, CONTROL_NOTE[7], 7'd1);
        midi(ST_ON, 7'd127, 7'd64);
        // Hold the device button and switch to sequencer layout one, then to
        // the same layout again, which changes nothing.
        midi(ST_ON, NOTE_DEVICE, 7'd100);
        midi(ST_ON, CONTROL_NOTE[0], 7'd100);
        midi(ST_ON, CONTROL_NOTE[0], 7'd100);
        midi(ST_OFF, NOTE_DEVICE, 7'd0);
        // Knob far from the stored value: not picked, so red or yellow.
        midi(ST_CC, KNOB_CC[0], 7'd90);
        // Step toggle, then a loop range from two held steps.
        midi(ST_ON, FOCUS_NOTE[3], 7'd90);
        midi(ST_OFF, FOCUS_NOTE[3], 7'd0);
        midi(ST_ON, CONTROL_NOTE[7], 7'd90);
        midi(ST_ON, FOCUS_NOTE[2], 7'd90);
        midi(ST_OFF, CONTROL_NOTE[7], 7'd0);
        midi(ST_ON, FOCUS_NOTE[2], 7'd0);
        // Message on another channel is ignored.
        send_request(1'b0, ST_CC, 4'd3, FADER_CC[1], 7'd9, 1'b0);
        // Takeover without a link, then again with a link: ignored once taken.
        send_request(1'b1, 4'hf, 4'hf, 7'h7f, 7'h7f, 1'b0);
        send_request(1'b1, 4'h0, 4'h0, 7'h00, 7'h00, 1'b1);
        drain();

        // Random phases under varying settings, extremes among them. The
        // pause before every write also gives the sender its full wait.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(REG_MIDI_CHANNEL, 7'd15); write_reg(REG_PICKUP_WINDOW, 7'd0); end
                1: begin write_reg(REG_MIDI_CHANNEL, 7'd0); write_reg(REG_PICKUP_WINDOW, 7'd127); end
                2: write_reg(REG_PICKUP_WINDOW, 7'd2);
                default: begin
                    write_reg(REG_MIDI_CHANNEL, rnd7(0, 127));
                    write_reg(REG_PICKUP_WINDOW, rnd7(0, 127));
                end
            endcase
            // A takeover with a link only fires when nothing has taken over
            // yet; a reset is not repeated, so this covers later phases too.
            for (int n = 0; n < 50; n++) random_request();
            drain();
        end

        if (fail_count == 0) begin
            $display("midi_control_surface_mapper_test OK");
        end
        else begin
            $display("midi_control_surface_mapper_test NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/mcsm_pkg.sv
src/mcsm_if.sv
src/mcsm_ram.sv
src/mcsm_front.sv
src/mcsm_cmd_fifo.sv
src/mcsm_back.sv
src/midi_control_surface_mapper.sv
dv/midi_control_surface_mapper_checker.sv
dv/midi_control_surface_mapper_test.sv
